// ===== sv/sevt_pkg.sv =====
// Shared types and constants for the sync event table.
// No dependencies; imported by every module of the block.
package sevt_pkg;

    localparam logic [31:0] ID_START = 32'h0000_6000;
    localparam logic [31:0] NO_ID    = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        OP_CREATE = 2'd0,
        OP_SIGNAL = 2'd1,
        OP_RESET  = 2'd2,
        OP_WAIT   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK           = 2'd0,
        STAT_FULL         = 2'd1,
        STAT_NOT_FOUND    = 2'd2,
        STAT_NOT_SIGNALED = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_SCAN
    } state_t;

    // one table entry
    typedef struct packed {
        logic [31:0] ident;
        logic [7:0]  kind;
        logic        flag;
        logic        manual;
    } slot_t;

    // controller -> datapath
    typedef struct packed {
        logic    load_req;
        logic    do_create;
        logic    do_update;
        logic    respond;
        status_t rsp_status;
        logic    rsp_new_id;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic table_full;
        logic table_empty;
        logic hit;
        logic at_last;
        logic flag_set;
        op_t  op_q;
    } dp_stat_t;

endpackage

// ===== sv/sevt_dp.sv =====
// Datapath of the sync event table: slot memory, fill count, id counter,
// scan address pipeline and result registers. Depends on sevt_pkg.
module sevt_dp
    import sevt_pkg::*;
#(
    parameter int SLOTS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  ctrl_cmd_t   cmd,
    output dp_stat_t    stat,
    input  logic [1:0]  op,
    input  logic [31:0] event_ident,
    input  logic [7:0]  obj_kind,
    input  logic        start_signaled,
    input  logic        manual_mode,
    output logic        done,
    output logic [1:0]  status,
    output logic [31:0] new_id
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    slot_t mem [SLOTS];

    // slots fill in order and are never freed: used means index < fill
    logic [CW-1:0] fill_reg, fill_next;
    logic [31:0]   next_ident_reg, next_ident_next;
    logic [AW-1:0] scan_addr_reg, scan_addr_next;
    logic [AW-1:0] cmp_addr_reg;
    slot_t         rdata_reg;
    op_t           op_q_reg;
    logic [31:0]   id_q_reg;
    logic          done_reg, done_next;
    logic [1:0]    status_reg;
    logic [31:0]   new_id_reg;
    slot_t         wr_data;
    logic          upd_flag;

    always_comb
    begin
        fill_next       = fill_reg;
        next_ident_next = next_ident_reg;
        if (cmd.do_create)
        begin
            fill_next       = fill_reg + CW'(1);
            next_ident_next = next_ident_reg + 32'd1;
        end
    end

    always_comb
    begin
        if (cmd.load_req)
            scan_addr_next = '0;
        else if (scan_addr_reg == AW'(SLOTS - 1))
            scan_addr_next = scan_addr_reg;
        else
            scan_addr_next = scan_addr_reg + AW'(1);
    end

    always_comb
    begin
        case (op_q_reg)
            OP_SIGNAL: upd_flag = 1'b1;
            OP_RESET:  upd_flag = 1'b0;
            OP_WAIT:   upd_flag = rdata_reg.manual;
            default:   upd_flag = rdata_reg.flag;
        endcase
        wr_data      = rdata_reg;
        wr_data.flag = upd_flag;
    end

    assign done_next = cmd.respond;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg       <= '0;
            next_ident_reg <= ID_START;
            done_reg       <= 1'b0;
        end
        else
        begin
            fill_reg       <= fill_next;
            next_ident_reg <= next_ident_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_addr_reg <= scan_addr_next;
        cmp_addr_reg  <= scan_addr_reg;
        if (cmd.load_req)
        begin
            op_q_reg <= op_t'(op);
            id_q_reg <= event_ident;
        end
        if (cmd.respond)
        begin
            status_reg <= cmd.rsp_status;
            new_id_reg <= cmd.rsp_new_id ? next_ident_reg : NO_ID;
        end
    end

    // slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.do_create)
            mem[fill_reg[AW-1:0]] <= '{ident: next_ident_reg, kind: obj_kind,
                                       flag: start_signaled, manual: manual_mode};
        else if (cmd.do_update)
            mem[cmp_addr_reg] <= wr_data;
        rdata_reg <= mem[scan_addr_reg];
    end

    assign stat.table_full  = (fill_reg == CW'(SLOTS));
    assign stat.table_empty = (fill_reg == '0);
    assign stat.hit         = (rdata_reg.ident == id_q_reg);
    assign stat.at_last     = (fill_reg == (CW'(cmp_addr_reg) + CW'(1)));
    assign stat.flag_set    = rdata_reg.flag;
    assign stat.op_q        = op_q_reg;

    assign done   = done_reg;
    assign status = status_reg;
    assign new_id = new_id_reg;

endmodule

// ===== sv/sevt_ctrl.sv =====
// Controller of the sync event table: sequences create, lookup scan and
// write-back. Depends on sevt_pkg; drives the datapath in sevt_dp.
module sevt_ctrl
    import sevt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] op,
    input  dp_stat_t   stat,
    output ctrl_cmd_t  cmd,
    output logic       busy
);

    state_t state_reg, state_next;
    logic   is_create;

    assign is_create = (op_t'(op) == OP_CREATE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start && !is_create && !stat.table_empty)
                    state_next = S_FETCH;
            end
            S_FETCH:
                state_next = S_SCAN;
            S_SCAN:
            begin
                if (stat.hit || stat.at_last)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '{load_req: 1'b0, do_create: 1'b0, do_update: 1'b0, respond: 1'b0,
                rsp_status: STAT_OK, rsp_new_id: 1'b0};
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (is_create)
                    begin
                        cmd.respond = 1'b1;
                        if (stat.table_full)
                            cmd.rsp_status = STAT_FULL;
                        else
                        begin
                            cmd.do_create  = 1'b1;
                            cmd.rsp_new_id = 1'b1;
                        end
                    end
                    else if (stat.table_empty)
                    begin
                        cmd.respond    = 1'b1;
                        cmd.rsp_status = STAT_NOT_FOUND;
                    end
                    else
                        cmd.load_req = 1'b1;
                end
            end
            S_SCAN:
            begin
                if (stat.hit)
                begin
                    cmd.respond = 1'b1;
                    if (stat.op_q == OP_WAIT && !stat.flag_set)
                        cmd.rsp_status = STAT_NOT_SIGNALED;
                    else
                        cmd.do_update = 1'b1;
                end
                else if (stat.at_last)
                begin
                    cmd.respond    = 1'b1;
                    cmd.rsp_status = STAT_NOT_FOUND;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== sv/sync_event_table_core.sv =====
// Top level of the sync event table: controller plus datapath.
// Depends on sevt_pkg, sevt_ctrl and sevt_dp.
//
//  channel   ports                                           transfer when
//  --------  ----------------------------------------------  ------------------
//  request   start, busy, op, event_ident, obj_kind,          start && !busy
//            start_signaled, manual_mode
//  result    done, status, new_id                            done (one cycle)
//
// Create, and any lookup on an empty table, answer in the cycle after the
// request (busy never rises). Signal, reset and wait scan the filled
// slots in order through the registered memory read port, and done rises
// once the match or the last filled slot has been compared; busy falls in
// the same cycle that done rises, so the next request can transfer while
// the result is on the ports.
// Reset clears the fill count, the id counter (to 0x6000) and the FSM; the
// slot memory needs no clearing since only filled slots are ever compared.
// The receiver cannot stall: each result is shown for exactly one cycle.
module sync_event_table_core
    import sevt_pkg::*;
#(
    parameter int SLOTS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [31:0] event_ident,
    input  logic [7:0]  obj_kind,
    input  logic        start_signaled,
    input  logic        manual_mode,
    output logic        done,
    output logic [1:0]  status,
    output logic [31:0] new_id
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    // sequencer: idle / fetch (first read in flight) / scan
    sevt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (op),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // slot memory, counters and result registers
    sevt_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .op             (op),
        .event_ident    (event_ident),
        .obj_kind       (obj_kind),
        .start_signaled (start_signaled),
        .manual_mode    (manual_mode),
        .done           (done),
        .status         (status),
        .new_id         (new_id)
    );

`ifndef SYNTHESIS
    // an accepted request is either answered next cycle or keeps the block busy
    a_req_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("request neither answered nor in progress");

    // only a successful create carries an identifier
    a_id_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != STAT_OK) |-> (new_id == NO_ID))
        else $error("identifier on a failed result");

    // a scan does not end in the fetch state: busy holds until the first compare
    a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && !$past(busy) && $past(start)) |=> busy)
        else $error("scan ended before first compare");
`endif

endmodule

// ===== tb/sv/sevt_result_checker.sv =====
// Result checker for the sync event table: watches request and result transfers,
// keeps a shadow of the event table and compares every result in order.
// Depends on sevt_pkg.
module sevt_result_checker
    import sevt_pkg::*;
#(
    parameter int SLOTS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  op,
    input  logic [31:0] event_ident,
    input  logic [7:0]  obj_kind,
    input  logic        start_signaled,
    input  logic        manual_mode,
    input  logic        done,
    input  logic [1:0]  status,
    input  logic [31:0] new_id,
    output int          fail_count,
    output int          outstanding
);

    typedef struct {
        status_t     status;
        logic [31:0] new_id;
    } event_result_t;

    // shadow event table
    logic        ev_in_use [SLOTS];
    logic [31:0] ev_ident  [SLOTS];
    logic [7:0]  ev_kind   [SLOTS];
    logic        ev_flag   [SLOTS];
    logic        ev_manual [SLOTS];
    logic [31:0] ident_counter;

    event_result_t expected_results[$];

    // Applies one request to the shadow table and returns its answer.
    function automatic event_result_t predict_event_op(input op_t o, input logic [31:0] id,
                                                       input logic [7:0] k, input logic s,
                                                       input logic m);
        event_result_t r;
        int            hit;
        r.status = STAT_OK;
        r.new_id = NO_ID;
        hit      = -1;
        if (o == OP_CREATE) begin
            for (int i = 0; i < SLOTS; i++)
                if (hit < 0 && !ev_in_use[i])
                    hit = i;
            if (hit < 0) begin
                r.status = STAT_FULL;
            end else begin
                ev_in_use[hit] = 1'b1;
                ev_ident[hit]  = ident_counter;
                ev_kind[hit]   = k;
                ev_flag[hit]   = s;
                ev_manual[hit] = m;
                r.new_id       = ident_counter;
                ident_counter  = ident_counter + 32'd1;
            end
        end else begin
            for (int i = 0; i < SLOTS; i++)
                if (hit < 0 && ev_in_use[i] && ev_ident[i] == id)
                    hit = i;
            if (hit < 0)
                r.status = STAT_NOT_FOUND;
            else if (o == OP_SIGNAL)
                ev_flag[hit] = 1'b1;
            else if (o == OP_RESET)
                ev_flag[hit] = 1'b0;
            else if (ev_flag[hit]) begin
                if (!ev_manual[hit])
                    ev_flag[hit] = 1'b0;
            end else
                r.status = STAT_NOT_SIGNALED;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        event_result_t want;
        if (!rst_n) begin
            for (int i = 0; i < SLOTS; i++)
                ev_in_use[i] = 1'b0;
            ident_counter = ID_START;
            expected_results.delete();
            outstanding <= 0;
            fail_count  <= 0;
        end else begin
            // result first: it always belongs to an earlier request
            if (done) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result: expected none, got status %0d new_id %h",
                             $time, status, new_id);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (status !== want.status || new_id !== want.new_id) begin
                        $display({"%0t: result mismatch: expected status %0d new_id %h,",
                                  " got status %0d new_id %h"},
                                 $time, want.status, want.new_id, status, new_id);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy)
                expected_results.push_back(predict_event_op(op_t'(op), event_ident, obj_kind,
                                                            start_signaled, manual_mode));
            outstanding <= expected_results.size();
        end
    end

endmodule

// ===== tb/sv/tb_sync_event_table_core.sv =====
// Testbench top for sync_event_table_core: drives directed and random requests
// and gives the verdict. Depends on sevt_pkg, sync_event_table_core, sevt_result_checker.
module tb_sync_event_table_core
    import sevt_pkg::*;
();

    localparam int TABLE_SLOTS  = 32;
    localparam int RANDOM_ITEMS = 800;
    localparam int DRAIN_CYCLES = 40;      // covers the worst-case scan of a full table
    localparam int CYCLE_LIMIT  = 400000;  // ~825 items and their idle gaps, many times over

    logic        clk;
    logic        rst_n          = 1'b0;
    logic        start          = 1'b0;
    logic        busy;
    logic [1:0]  op             = 2'd0;
    logic [31:0] event_ident    = 32'd0;
    logic [7:0]  obj_kind       = 8'd0;
    logic        start_signaled = 1'b0;
    logic        manual_mode    = 1'b0;
    logic        done;
    logic [1:0]  status;
    logic [31:0] new_id;

    int fail_count;
    int outstanding;
    int cycle_count   = 0;
    int idle_pct      = 0;   // chance per cycle that the sender holds off
    int events_made   = 0;   // successful creates so far; ids are ID_START + n

    sync_event_table_core #(
        .SLOTS          (TABLE_SLOTS)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .op             (op),
        .event_ident    (event_ident),
        .obj_kind       (obj_kind),
        .start_signaled (start_signaled),
        .manual_mode    (manual_mode),
        .done           (done),
        .status         (status),
        .new_id         (new_id)
    );

    sevt_result_checker #(
        .SLOTS          (TABLE_SLOTS)
    ) result_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .op             (op),
        .event_ident    (event_ident),
        .obj_kind       (obj_kind),
        .start_signaled (start_signaled),
        .manual_mode    (manual_mode),
        .done           (done),
        .status         (status),
        .new_id         (new_id),
        .fail_count     (fail_count),
        .outstanding    (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // watchdog: a hung handshake or a lost result ends up here
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // One request transfer. Optional idle cycles first, then start is held
    // until a clock edge sees busy low. Returns on the transfer edge so the
    // next call can keep start high without a drop.
    task automatic issue_request(input op_t o, input logic [31:0] id, input logic [7:0] k,
                                 input logic s, input logic m);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start          <= 1'b1;
        op             <= o;
        event_ident    <= id;
        obj_kind       <= k;
        start_signaled <= s;
        manual_mode    <= m;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (o == OP_CREATE && events_made < TABLE_SLOTS)
            events_made++;
    endtask

    // Pick an identifier: mostly a live one, sometimes the next unissued
    // id or an arbitrary 32-bit value (not found).
    function automatic logic [31:0] pick_ident();
        int sel;
        sel = $urandom_range(99);
        if (events_made > 0 && sel < 75)
            return ID_START + $urandom_range(events_made - 1);
        else if (sel < 85)
            return ID_START + events_made;
        else if (sel < 90)
            return ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'h0000_0000;
        else
            return $urandom;
    endfunction

    task automatic random_request();
        op_t o;
        // creates are kept sparse so the table fills gradually; once full,
        // an occasional create checks the full answer
        if (events_made < TABLE_SLOTS)
            o = ($urandom_range(7) == 0) ? OP_CREATE : op_t'(2'($urandom_range(1, 3)));
        else
            o = ($urandom_range(15) == 0) ? OP_CREATE : op_t'(2'($urandom_range(1, 3)));
        issue_request(o, (o == OP_CREATE) ? 32'($urandom) : pick_ident(),
                      8'($urandom), 1'($urandom), 1'($urandom));
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: lookups on an empty table
        issue_request(OP_SIGNAL, ID_START,     8'h00, 1'b0, 1'b0);
        issue_request(OP_WAIT,   32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b1);
        issue_request(OP_RESET,  32'h0000_0000, 8'h00, 1'b0, 1'b0);
        // creates with extreme kinds and every flag mix
        issue_request(OP_CREATE, 32'hFFFF_FFFF, 8'h00, 1'b1, 1'b0);   // auto, signaled
        issue_request(OP_CREATE, 32'h0000_0000, 8'hFF, 1'b0, 1'b1);   // manual, clear
        issue_request(OP_CREATE, 32'h5A5A_A5A5, 8'hA5, 1'b1, 1'b1);   // manual, signaled
        issue_request(OP_CREATE, 32'h0000_0000, 8'h5A, 1'b0, 1'b0);   // auto, clear
        // auto-reset: wait consumes the flag, second wait is not signaled
        issue_request(OP_WAIT,   ID_START,          8'h00, 1'b0, 1'b0);
        issue_request(OP_WAIT,   ID_START,          8'h00, 1'b0, 1'b0);
        // manual-reset: flag stays set across waits until reset
        issue_request(OP_WAIT,   ID_START + 32'd1, 8'h00, 1'b0, 1'b0);
        issue_request(OP_SIGNAL, ID_START + 32'd1, 8'h00, 1'b0, 1'b0);
        issue_request(OP_WAIT,   ID_START + 32'd1, 8'h00, 1'b0, 1'b0);
        issue_request(OP_WAIT,   ID_START + 32'd1, 8'h00, 1'b0, 1'b0);
        issue_request(OP_RESET,  ID_START + 32'd1, 8'h00, 1'b0, 1'b0);
        issue_request(OP_WAIT,   ID_START + 32'd1, 8'h00, 1'b0, 1'b0);
        issue_request(OP_WAIT,   ID_START + 32'd2, 8'hFF, 1'b1, 1'b1);
        // signal then wait on an auto slot, and ids just outside the live range
        issue_request(OP_SIGNAL, ID_START + 32'd3, 8'h00, 1'b0, 1'b0);
        issue_request(OP_WAIT,   ID_START + 32'd3, 8'h00, 1'b0, 1'b0);
        issue_request(OP_RESET,  ID_START + 32'd4, 8'h00, 1'b0, 1'b0);
        issue_request(OP_SIGNAL, ID_START - 32'd1, 8'h00, 1'b0, 1'b0);

        // random part in three pacing phases: moderate, heavy, no gaps
        idle_pct = 29;
        repeat (RANDOM_ITEMS / 3) random_request();
        idle_pct = 57;
        repeat (RANDOM_ITEMS / 3) random_request();
        idle_pct = 0;
        repeat (RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3)) random_request();

        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
